/* hw/rtl/drt_pkg.sv */
// shared types and constants for the datagram reassembly tracker
`default_nettype none

package drt_pkg;

	localparam int unsigned FRAGMENT_BYTES_DEF = 1024;
	localparam int unsigned SEQ_W              = 31;
	localparam int unsigned BYTES_W            = 16;
	localparam int unsigned LEN_W              = 17;
	// holds any slot number the 16-bit offset can reach for fragment sizes of 256 bytes or more
	localparam int unsigned SLOT_W             = 8;
	localparam int unsigned QUEUE_DEPTH        = 4;
	localparam logic [LEN_W-1:0] LEN_LIMIT     = 17'd65536;

	typedef enum logic [2:0] {
		V_SINGLE  = 3'd0,
		V_REASM   = 3'd1,
		V_PENDING = 3'd2,
		V_STALE   = 3'd3,
		V_RANGE   = 3'd4,
		V_DUP     = 3'd5
	} verdict_t;

	// one classified header handed from the front stage to the back stage
	typedef struct packed {
		logic               is_fragment;
		logic [SEQ_W-1:0]   seq;
		logic [SLOT_W-1:0]  slot;
		logic               in_range;
		logic               is_short;
		logic [BYTES_W-1:0] payload;
	} item_t;

endpackage : drt_pkg

`default_nettype wire

/* hw/rtl/datagram_reassembly_tracker_core.sv */
// top level of the datagram reassembly tracker
// Usage:
//   The input channel takes one parsed header request per cycle when ready (in_valid/in_ready):
//   fragment flag, sequence number, fragment offset, fragment size and payload bytes.
//   The output channel (out_valid/out_ready) returns exactly one result per request,
//   in order: verdict, gap flag, buffer write offset and delivered message length.
// Pipeline and throughput:
//   An accepted request passes these steps in order: the front stage register takes it
//   with the slot from the multiply, the queue stores it, and the back stage updates
//   tracking state and loads the output register, whose result shows on out_valid.
//   Throughput is one request per cycle while out_ready does not stall the output;
//   the back stage reads and updates the sequence state and slot bitmap in the same cycle.
// Stall:
//   If out_ready is low the result waits in the output register while the queue
//   (four entries) and the front stage keep taking requests; in_ready drops only
//   once both are full.
// Reset:
//   arst_n clears the sequence state, the slot bitmap and all valid flags at once;
//   requests are taken from the first cycle after reset.
`default_nettype none

module datagram_reassembly_tracker_core #(
	parameter int unsigned FRAGMENT_BYTES = drt_pkg::FRAGMENT_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         is_fragment,
	input  wire logic [drt_pkg::SEQ_W-1:0]    seq_number,
	input  wire logic [drt_pkg::BYTES_W-1:0]  frag_offset,
	input  wire logic [drt_pkg::BYTES_W-1:0]  frag_size_field,
	input  wire logic [drt_pkg::BYTES_W-1:0]  payload_bytes,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        verdict,
	output logic                              gap_seen,
	output logic [drt_pkg::BYTES_W-1:0]       write_offset,
	output logic [drt_pkg::LEN_W-1:0]         message_length
);
	import drt_pkg::*;

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	drt_front #(
		.FRAGMENT_BYTES (FRAGMENT_BYTES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.is_fragment     (is_fragment),
		.seq_number      (seq_number),
		.frag_offset     (frag_offset),
		.frag_size_field (frag_size_field),
		.payload_bytes   (payload_bytes),
		.push            (push),
		.push_item       (push_item),
		.queue_full      (queue_full)
	);

	drt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	drt_back #(
		.FRAGMENT_BYTES (FRAGMENT_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.verdict        (verdict),
		.gap_seen       (gap_seen),
		.write_offset   (write_offset),
		.message_length (message_length)
	);

endmodule : datagram_reassembly_tracker_core

`default_nettype wire

/* hw/rtl/drt_front.sv */
// front stage: accepts headers, derives fragment slot and last-fragment flag
`default_nettype none

module drt_front #(
	parameter int unsigned FRAGMENT_BYTES = drt_pkg::FRAGMENT_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         is_fragment,
	input  wire logic [drt_pkg::SEQ_W-1:0]    seq_number,
	input  wire logic [drt_pkg::BYTES_W-1:0]  frag_offset,
	input  wire logic [drt_pkg::BYTES_W-1:0]  frag_size_field,
	input  wire logic [drt_pkg::BYTES_W-1:0]  payload_bytes,
	output logic                              push,
	output drt_pkg::item_t                    push_item,
	input  wire logic                         queue_full
);
	import drt_pkg::*;

	localparam int unsigned SLOT_COUNT = 65536 / FRAGMENT_BYTES;
	// offset / FRAGMENT_BYTES done as multiply by a rounded-up reciprocal, exact for 16 bits
	localparam int unsigned FB_LOG   = $clog2(FRAGMENT_BYTES);
	localparam int unsigned FRAC     = BYTES_W + FB_LOG;
	localparam longint unsigned RECIP =
		((64'd1 << FRAC) + 64'(FRAGMENT_BYTES) - 64'd1) / 64'(FRAGMENT_BYTES);
	localparam int unsigned PROD_W   = FRAC + SLOT_W;

	logic [PROD_W-1:0]  product;
	logic               valid_s1;
	logic               frag_s1;
	logic [SEQ_W-1:0]   seq_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic               short_s1;
	logic [BYTES_W-1:0] pay_s1;
	logic               accept;

	assign product  = PROD_W'(frag_offset) * PROD_W'(RECIP);
	assign in_ready = !valid_s1 || !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frag_s1  <= is_fragment;
			seq_s1   <= seq_number;
			slot_s1  <= product[PROD_W-1 -: SLOT_W];
			short_s1 <= (frag_size_field != BYTES_W'(FRAGMENT_BYTES));
			pay_s1   <= payload_bytes;
		end
	end

	always_comb begin
		push_item.is_fragment = frag_s1;
		push_item.seq         = seq_s1;
		push_item.slot        = slot_s1;
		push_item.in_range    = ({1'b0, slot_s1} < (SLOT_W + 1)'(SLOT_COUNT));
		push_item.is_short    = short_s1;
		push_item.payload     = pay_s1;
	end

endmodule : drt_front

`default_nettype wire

/* hw/rtl/drt_queue.sv */
// short queue between the front and back stages
`default_nettype none

module drt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire drt_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output drt_pkg::item_t      head_item
);
	import drt_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entries [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entries[wr_ptr_q] <= push_item;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule : drt_queue

`default_nettype wire

/* hw/rtl/drt_back.sv */
// back stage: sequencing state, slot bitmap, verdict and output register
`default_nettype none

module drt_back #(
	parameter int unsigned FRAGMENT_BYTES = drt_pkg::FRAGMENT_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire drt_pkg::item_t               head_item,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        verdict,
	output logic                              gap_seen,
	output logic [drt_pkg::BYTES_W-1:0]       write_offset,
	output logic [drt_pkg::LEN_W-1:0]         message_length
);
	import drt_pkg::*;

	localparam int unsigned SLOT_COUNT = 65536 / FRAGMENT_BYTES;
	localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);

	// tracking state
	logic [SEQ_W-1:0]      last_seq_q;
	logic [SEQ_W-1:0]      tracked_seq_q;
	logic                  tracked_valid_q;
	logic [SLOT_COUNT-1:0] map_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      final_slot_q;
	logic                  final_known_q;
	logic [LEN_W-1:0]      acc_len_q;

	logic [SEQ_W-1:0]      last_seq_n;
	logic [SEQ_W-1:0]      tracked_seq_n;
	logic                  tracked_valid_n;
	logic [SLOT_COUNT-1:0] map_n;
	logic [CNT_W-1:0]      count_n;
	logic [IDX_W-1:0]      final_slot_n;
	logic                  final_known_n;
	logic [LEN_W-1:0]      acc_len_n;

	verdict_t              verdict_n;
	logic                  gap_n;
	logic [BYTES_W-1:0]    wofs_n;
	logic [LEN_W-1:0]      mlen_n;

	logic                  stale;
	logic                  new_seq;
	logic [IDX_W-1:0]      idx;
	logic [LEN_W:0]        len_sum;
	logic [31:0]           wofs_full;

	// output register
	logic                  out_valid_q;
	verdict_t              verdict_q;
	logic                  gap_q;
	logic [BYTES_W-1:0]    wofs_q;
	logic [LEN_W-1:0]      mlen_q;

	assign pop          = head_valid && (!out_valid_q || out_ready);
	assign idx          = head_item.slot[IDX_W-1:0];
	assign wofs_full    = 32'(head_item.slot) * 32'(FRAGMENT_BYTES);
	assign stale        = (head_item.seq <= last_seq_q) && (last_seq_q != '0);
	assign new_seq      = !tracked_valid_q || (head_item.seq != tracked_seq_q);

	always_comb begin
		last_seq_n      = last_seq_q;
		tracked_seq_n   = tracked_seq_q;
		tracked_valid_n = tracked_valid_q;
		map_n           = map_q;
		count_n         = count_q;
		final_slot_n    = final_slot_q;
		final_known_n   = final_known_q;
		acc_len_n       = acc_len_q;
		verdict_n       = V_STALE;
		gap_n           = 1'b0;
		wofs_n          = '0;
		mlen_n          = '0;
		len_sum         = '0;
		if (!stale) begin
			gap_n = ({1'b0, head_item.seq} > ({1'b0, last_seq_q} + (SEQ_W + 1)'(1)));
			if (!head_item.is_fragment) begin
				verdict_n  = V_SINGLE;
				mlen_n     = LEN_W'(head_item.payload);
				last_seq_n = head_item.seq;
			end else begin
				// a new sequence restarts tracking before the slot is looked at
				if (new_seq) begin
					map_n         = '0;
					count_n       = '0;
					final_slot_n  = '0;
					final_known_n = 1'b0;
					acc_len_n     = '0;
				end
				tracked_seq_n   = head_item.seq;
				tracked_valid_n = 1'b1;
				if (!head_item.in_range) begin
					verdict_n = V_RANGE;
				end else begin
					wofs_n = wofs_full[BYTES_W-1:0];
					if (map_n[idx]) begin
						verdict_n = V_DUP;
					end else begin
						map_n[idx] = 1'b1;
						count_n    = count_n + CNT_W'(1);
						len_sum    = {1'b0, acc_len_n} + (LEN_W + 1)'(head_item.payload);
						acc_len_n  = (len_sum > (LEN_W + 1)'(LEN_LIMIT)) ? LEN_LIMIT
							: len_sum[LEN_W-1:0];
						if (head_item.is_short) begin
							final_slot_n  = idx;
							final_known_n = 1'b1;
						end
						if (!final_known_n || (count_n <= CNT_W'(final_slot_n))) begin
							verdict_n = V_PENDING;
						end else begin
							verdict_n  = V_REASM;
							last_seq_n = head_item.seq;
							mlen_n     = acc_len_n;
							acc_len_n  = '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q      <= '0;
			tracked_seq_q   <= '0;
			tracked_valid_q <= 1'b0;
			map_q           <= '0;
			count_q         <= '0;
			final_slot_q    <= '0;
			final_known_q   <= 1'b0;
			acc_len_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				last_seq_q      <= last_seq_n;
				tracked_seq_q   <= tracked_seq_n;
				tracked_valid_q <= tracked_valid_n;
				map_q           <= map_n;
				count_q         <= count_n;
				final_slot_q    <= final_slot_n;
				final_known_q   <= final_known_n;
				acc_len_q       <= acc_len_n;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_n;
			gap_q     <= gap_n;
			wofs_q    <= wofs_n;
			mlen_q    <= mlen_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign gap_seen       = gap_q;
	assign write_offset   = wofs_q;
	assign message_length = mlen_q;

	a_count_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(map_q) == int'(count_q))
		else $error("slot count out of step with bitmap");

	a_len_cleared_on_reasm: assert property (@(posedge clk) disable iff (!arst_n)
		pop && verdict_n == V_REASM |=> acc_len_q == '0)
		else $error("length not restarted after reassembly");

	a_len_only_on_delivery: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mlen_q != '0 |-> verdict_q == V_SINGLE || verdict_q == V_REASM)
		else $error("message length on a request that was not delivered");

endmodule : drt_back

`default_nettype wire
